>>> sv/n2a_pkg.sv
// Shared types, constants and helpers for the number to ASCII formatter.
`default_nettype none

package n2a_pkg;

  localparam int unsigned MAG_W      = 32;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned PAD_W      = BCD_W - 16;

  localparam logic [1:0] FMT_DEC = 2'd0;
  localparam logic [1:0] FMT_HEX = 2'd1;
  localparam logic [1:0] FMT_BIN = 2'd2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;

  localparam logic [CNT_W-1:0] DEC_DIGITS = 5'd10;
  localparam logic [CNT_W-1:0] HEX_DIGITS = 5'd4;
  localparam logic [CNT_W-1:0] BIN_DIGITS = 5'd16;

  localparam logic [STEP_W-1:0] LAST_STEP = 5'd31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_e;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {3'b000, d};
    if (d > 4'd9) begin
      digit_char = ASCII_A + dx - 7'd10;
    end else begin
      digit_char = ASCII_ZERO + dx;
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/n2a_if.sv
// Valid/ready channel interfaces for the number and character streams.
`default_nettype none

interface n2a_in_if import n2a_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [MAG_W-1:0] value;
  logic [1:0]        opcode;

  modport source (output valid, output value, output opcode, input ready);
  modport sink   (input valid, input value, input opcode, output ready);
endinterface

interface n2a_out_if import n2a_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

>>> sv/number_to_ascii_formatter_core.sv
// Top level: formats a number as decimal, hex or binary ASCII characters.
//
//   channel | dir | payload               | transaction
//   in_i    | in  | value[31:0], opcode   | one number to format
//   out_o   | out | char_code[6:0], last  | one character, MSB first
//
// One number at a time; format code 3 is taken and dropped. Decimal: the
// value goes through the double-dabble shifter, its digits are loaded, a
// minus sign is sent if negative, then leading zeros are skipped and the
// other digits sent. Hex: every digit sent. Binary: leading zeros skipped.
// A registered output stage holds each character until it is taken; a stall
// on out_o freezes the digit shifter; leading zeros are still skipped.
// Reset returns the sequencer to idle with the output stage empty.
`default_nettype none

module number_to_ascii_formatter_core import n2a_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  n2a_in_if.sink     in_i,
  n2a_out_if.source  out_o
);

  state_e             state_q, state_d;
  logic [BCD_W-1:0]   dig_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               wide_q;
  logic               skip_q;
  logic               neg_q;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;

  logic               accept;
  logic               slot_free;
  logic [3:0]         digit;
  logic               drop;
  logic               emit_dig;
  logic               emit_sign;
  logic               advance;
  logic [MAG_W-1:0]   raw;
  logic [MAG_W-1:0]   mag;
  logic               dab_start;
  logic               dab_done;
  logic [BCD_W-1:0]   dab_bcd;

  assign accept    = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign raw       = in_i.value;
  assign mag       = raw[MAG_W-1] ? (~raw + 1'b1) : raw;
  assign dab_start = accept && (in_i.opcode == FMT_DEC);

  n2a_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dab_start),
    .mag_i   (mag),
    .done_o  (dab_done),
    .bcd_o   (dab_bcd)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_i.opcode)
            FMT_DEC: state_d = ST_CONV;
            FMT_HEX: state_d = ST_EMIT;
            FMT_BIN: state_d = ST_EMIT;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CONV: begin
        if (dab_done) begin
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_dig && (cnt_q == 5'd1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    digit     = wide_q ? dig_q[BCD_W-1 -: 4] : {3'b000, dig_q[BCD_W-1]};
    drop      = (state_q == ST_EMIT) && skip_q && (digit == 4'd0) && (cnt_q > 5'd1);
    emit_dig  = (state_q == ST_EMIT) && !drop && slot_free;
    emit_sign = (state_q == ST_SIGN) && slot_free;
    advance   = drop || emit_dig;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit_dig || emit_sign) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q <= (in_i.opcode == FMT_DEC) && raw[MAG_W-1];
      dig_q <= {raw[15:0], {PAD_W{1'b0}}};
      wide_q <= (in_i.opcode != FMT_BIN);
      skip_q <= (in_i.opcode != FMT_HEX);
      cnt_q  <= (in_i.opcode == FMT_BIN) ? BIN_DIGITS : HEX_DIGITS;
    end else if ((state_q == ST_CONV) && dab_done) begin
      dig_q  <= dab_bcd;
      cnt_q  <= DEC_DIGITS;
      wide_q <= 1'b1;
      skip_q <= 1'b1;
    end else if (advance) begin
      dig_q <= wide_q ? {dig_q[BCD_W-5:0], 4'h0} : {dig_q[BCD_W-2:0], 1'b0};
      cnt_q <= cnt_q - 1'b1;
      if (emit_dig) begin
        skip_q <= 1'b0;
      end
    end

    if (emit_sign) begin
      char_q <= ASCII_MINUS;
      last_q <= 1'b0;
    end else if (emit_dig) begin
      char_q <= digit_char(digit);
      last_q <= (cnt_q == 5'd1);
    end
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = char_q;
  assign out_o.last_char = last_q;

endmodule

`default_nettype wire

>>> sv/n2a_dabble.sv
// Bit-serial double-dabble converter: 32-bit magnitude to ten BCD digits.
`default_nettype none

module n2a_dabble import n2a_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [MAG_W-1:0] mag_i,
  output logic                  done_o,
  output logic [BCD_W-1:0]      bcd_o
);

  logic [MAG_W-1:0]  mag_q, mag_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d;
  logic [BCD_W-1:0]  adj;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
    bcd_d = {adj[BCD_W-2:0], mag_q[MAG_W-1]};
    mag_d = {mag_q[MAG_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= mag_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      mag_q <= mag_d;
      bcd_q <= bcd_d;
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

`default_nettype wire

>>> tb/sv/n2a_fmt_checker.sv
// Scoreboard for the number to ASCII formatter: predicts and checks every character.
module n2a_fmt_checker import n2a_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_i,
  input  wire logic [MAG_W-1:0]  in_value_i,
  input  wire logic [1:0]        in_opcode_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_ready_i,
  input  wire logic [CHAR_W-1:0] out_char_i,
  input  wire logic              out_last_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o,
  output int unsigned            numbers_o,
  output int unsigned            dropped_o,
  output int unsigned            chars_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_exp_t;

  char_exp_t expected_chars[$];
  char_exp_t oldest;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    numbers_o    = 0;
    dropped_o    = 0;
    chars_o      = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    if (fail_count_o <= 20) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic void push_char(input logic [CHAR_W-1:0] code);
    char_exp_t c;
    c.code = code;
    c.last = 1'b0;
    expected_chars.push_back(c);
  endfunction

  task automatic spell_number(input logic signed [MAG_W-1:0] value, input logic [1:0] opcode);
    logic [MAG_W-1:0]  mag;
    logic [3:0]        digits[10];
    logic [15:0]       low;
    logic [3:0]        nib;
    logic [CHAR_W-1:0] code;
    int                n;
    int                start_len;
    bit                seen;
    start_len = expected_chars.size();
    low = value[15:0];
    case (opcode)
      FMT_DEC: begin
        mag = value;
        if (value < 0) begin
          mag = -mag;
          push_char(ASCII_MINUS);
        end
        n = 0;
        do begin
          digits[n] = mag % 10;
          mag = mag / 10;
          n++;
        end while (mag != 0 && n < 10);
        for (int i = n - 1; i >= 0; i--) push_char(ASCII_ZERO + digits[i]);
      end
      FMT_HEX: begin
        for (int s = 3; s >= 0; s--) begin
          nib = low[s*4 +: 4];
          code = (nib > 4'd9) ? ASCII_A + nib - 7'd10 : ASCII_ZERO + nib;
          push_char(code);
        end
      end
      FMT_BIN: begin
        if (low == 16'd0) begin
          push_char(ASCII_ZERO);
        end else begin
          seen = 1'b0;
          for (int b = 15; b >= 0; b--) begin
            if (low[b]) seen = 1'b1;
            if (seen) push_char(ASCII_ZERO + low[b]);
          end
        end
      end
      default: ;
    endcase
    if (expected_chars.size() > start_len) begin
      expected_chars[expected_chars.size()-1].last = 1'b1;
      numbers_o++;
    end else begin
      dropped_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) spell_number(in_value_i, in_opcode_i);
      if (out_valid_i && out_ready_i) begin
        chars_o++;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character %h last %b", out_char_i, out_last_i));
        end else begin
          oldest = expected_chars.pop_front();
          if (out_char_i !== oldest.code)
            report_mismatch($sformatf("char_code %h, expected %h", out_char_i, oldest.code));
          if (out_last_i !== oldest.last)
            report_mismatch($sformatf("last_char %b, expected %b on char %h",
                                      out_last_i, oldest.last, oldest.code));
        end
      end
      pending_o = expected_chars.size();
    end
  end

endmodule

>>> tb/sv/tb_number_to_ascii_formatter_core.sv
// Testbench top: stimulus, output back-pressure and verdict for the formatter.
module tb_number_to_ascii_formatter_core;
  import n2a_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 430;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam logic [1:0]  FMT_NONE     = 2'd3;

  logic clk_i;
  logic rst_ni;

  n2a_in_if  in_if ();
  n2a_out_if out_if ();

  int unsigned fail_count;
  int unsigned chars_pending;
  int unsigned numbers_done;
  int unsigned dropped_done;
  int unsigned chars_done;
  int unsigned cycles;
  int unsigned burst_left;
  int unsigned sent;
  int unsigned drains;

  int unsigned stall_mode;
  int unsigned mode_left;
  int unsigned run_left;
  logic        run_ready;

  number_to_ascii_formatter_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  n2a_fmt_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .in_value_i   (in_if.value),
    .in_opcode_i  (in_if.opcode),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_char_i   (out_if.char_code),
    .out_last_i   (out_if.last_char),
    .fail_count_o (fail_count),
    .pending_o    (chars_pending),
    .numbers_o    (numbers_done),
    .dropped_o    (dropped_done),
    .chars_o      (chars_done)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL number_to_ascii_formatter_core");
      $finish;
    end
  end

  // Output back-pressure: free-running, random, or long stall runs.
  initial begin
    out_if.ready = 1'b0;
    stall_mode   = 0;
    mode_left    = 0;
    run_left     = 0;
    run_ready    = 1'b0;
  end

  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(40, 200);
    end
    mode_left--;
    case (stall_mode)
      0: out_if.ready = 1'b1;
      1: out_if.ready = ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          run_ready = ~run_ready;
          run_left  = run_ready ? $urandom_range(1, 8) : $urandom_range(1, 12);
        end
        run_left--;
        out_if.ready = run_ready;
      end
    endcase
  end

  // Called and returns at a falling edge, after the handshake and any idle gap.
  task automatic send_number(input logic signed [MAG_W-1:0] value, input logic [1:0] opcode);
    int unsigned gap;
    in_if.valid  = 1'b1;
    in_if.value  = value;
    in_if.opcode = opcode;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(1, 12);
      in_if.valid  = 1'b0;
      in_if.value  = $urandom;
      in_if.opcode = $urandom_range(0, 3);
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (chars_pending != 0) @(negedge clk_i);
    drains++;
  endtask

  function automatic logic signed [MAG_W-1:0] pick_decimal();
    logic signed [MAG_W-1:0] v;
    int unsigned             k;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 99);
      2: begin
        v = 1;
        k = $urandom_range(0, 9);
        repeat (k) v = v * 10;
        v = v + $urandom_range(0, 2) - 1;
      end
      default: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic logic signed [MAG_W-1:0] pick_binary();
    logic signed [MAG_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 4))
      0: v[15:0] = $urandom_range(0, 15);
      1: v[15:0] = 16'd0;
      2: v[15:0] = 16'd1 << $urandom_range(0, 15);
      default: ;
    endcase
    return v;
  endfunction

  logic signed [MAG_W-1:0] dir_value  [23];
  logic [1:0]              dir_opcode [23];

  initial begin
    dir_value = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd10, 32'h7FFF_FFFF, 32'h8000_0000,
      32'sd1000000000, -32'sd999999999, 32'sd123456789,
      32'h0000_0000, 32'h0000_FFFF, 32'h1234_ABCD, 32'hFFFF_5A0F, 32'h0000_89EF,
      32'h0000_0000, 32'h0001_0000, 32'h0000_0001, 32'h0000_8000, 32'hFFFF_FFFF,
      32'h7FFF_5555, 32'h1234_5678, 32'h0000_0000
    };
    dir_opcode = '{
      FMT_DEC, FMT_DEC, FMT_DEC, FMT_DEC, FMT_DEC, FMT_DEC, FMT_DEC,
      FMT_DEC, FMT_DEC, FMT_DEC,
      FMT_HEX, FMT_HEX, FMT_HEX, FMT_HEX, FMT_HEX,
      FMT_BIN, FMT_BIN, FMT_BIN, FMT_BIN, FMT_BIN,
      FMT_BIN, FMT_NONE, FMT_NONE
    };
  end

  initial begin
    logic [1:0] op;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    in_if.opcode = FMT_DEC;
    burst_left   = 4;
    sent         = 0;
    drains       = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_value[i]) send_number(dir_value[i], dir_opcode[i]);
    wait_drained();

    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6:      op = FMT_DEC;
        7, 8, 9, 10, 11, 12:      op = FMT_HEX;
        13, 14, 15, 16, 17, 18:   op = FMT_BIN;
        default:                  op = FMT_NONE;
      endcase
      case (op)
        FMT_DEC: send_number(pick_decimal(), op);
        FMT_BIN: send_number(pick_binary(), op);
        default: send_number($urandom, op);
      endcase
      if (op != FMT_NONE) sent++;
      if (sent == RANDOM_ITEMS / 2 || $urandom_range(0, 63) == 0) wait_drained();
    end

    in_if.valid = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Covered %0d formatted numbers and %0d dropped codes, %0d characters checked.",
             numbers_done, dropped_done, chars_done);
    $display("Output fully drained %0d times mid-run; %0d cycles.", drains, cycles);
    if (fail_count == 0) begin
      $display("PASS number_to_ascii_formatter_core");
    end else begin
      $display("FAIL number_to_ascii_formatter_core");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/n2a_pkg.sv
sv/n2a_if.sv
sv/n2a_dabble.sv
sv/number_to_ascii_formatter_core.sv
tb/sv/n2a_fmt_checker.sv
tb/sv/tb_number_to_ascii_formatter_core.sv
